[rtl/core/sqs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sprite quad setup package
// shared constants, types and tables for the sprite quad setup block
// ----------------------------------------------------------------------------
package sqs_pkg;

	localparam int BatchQuads   = 1024;
	localparam int CordicSteps  = 16;
	localparam int StepW        = 4;
	localparam int DivBits      = 33;
	localparam int DivCntW      = 6;

	localparam logic signed [18:0] Deg360 = 19'sd46080;
	localparam logic signed [18:0] Deg180 = 19'sd23040;
	localparam logic signed [18:0] Deg90  = 19'sd11520;
	localparam logic signed [27:0] CordicK24 = 28'sd10188014;
	localparam logic [12:0] BatchLimit = 13'(BatchQuads * 4);

	localparam logic [0:0] RegTexWidth  = 1'b0;
	localparam logic [0:0] RegTexHeight = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_CORDIC,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	function automatic logic [25:0] atan_lut(input logic [StepW-1:0] i);
		logic [25:0] r;
		case (i)
			4'd0:    r = 26'd2949120;
			4'd1:    r = 26'd1740967;
			4'd2:    r = 26'd919879;
			4'd3:    r = 26'd466945;
			4'd4:    r = 26'd234379;
			4'd5:    r = 26'd117266;
			4'd6:    r = 26'd58666;
			4'd7:    r = 26'd29335;
			4'd8:    r = 26'd14668;
			4'd9:    r = 26'd7334;
			4'd10:   r = 26'd3667;
			4'd11:   r = 26'd1833;
			4'd12:   r = 26'd917;
			4'd13:   r = 26'd458;
			4'd14:   r = 26'd229;
			4'd15:   r = 26'd115;
			default: r = 26'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/sqs_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sprite quad setup channels
// valid/ready channel interfaces for requests, vertices and register writes
// ----------------------------------------------------------------------------
interface sqs_req_if;
	logic        valid;
	logic        ready;
	logic [14:0] src_x;
	logic [14:0] src_y;
	logic [14:0] src_w;
	logic [14:0] src_h;
	logic signed [15:0] dest_x;
	logic signed [15:0] dest_y;
	logic [14:0] dest_w;
	logic [14:0] dest_h;
	logic signed [16:0] angle;
	logic signed [15:0] center_x;
	logic signed [15:0] center_y;
	logic [4:0]  flags;
	modport source (output valid, src_x, src_y, src_w, src_h, dest_x, dest_y, dest_w,
		dest_h, angle, center_x, center_y, flags, input ready);
	modport sink (input valid, src_x, src_y, src_w, src_h, dest_x, dest_y, dest_w,
		dest_h, angle, center_x, center_y, flags, output ready);
endinterface

interface sqs_vtx_if;
	logic        valid;
	logic        ready;
	logic signed [23:0] vertex_x;
	logic signed [23:0] vertex_y;
	logic [16:0] tex_u;
	logic [16:0] tex_v;
	logic [1:0]  corner;
	logic [11:0] vertex_slot;
	logic        last;
	modport source (output valid, vertex_x, vertex_y, tex_u, tex_v, corner, vertex_slot,
		last, input ready);
	modport sink (input valid, vertex_x, vertex_y, tex_u, tex_v, corner, vertex_slot,
		last, output ready);
endinterface

interface sqs_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/sqs_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sprite quad setup cordic
// rotation-mode cordic, one micro-rotation per cycle, then rounding to q1.16
// ----------------------------------------------------------------------------
module sqs_cordic (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sqs_pkg::unit_ctl_t  ctl,
	input  wire logic signed [26:0]  z_init,
	input  wire logic                neg,
	output logic                     done,
	output logic signed [17:0]       sin_val,
	output logic signed [17:0]       cos_val
);
	logic signed [27:0] x_q, y_q;
	logic signed [27:0] z_q;
	logic [sqs_pkg::StepW-1:0] step_q;
	logic run_q, neg_q, done_q;
	logic signed [27:0] xs, ys, xr, yr;
	logic signed [27:0] at;

	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = 28'(sqs_pkg::atan_lut(step_q));
	assign xr = (x_q + 28'sd128) >>> 8;
	assign yr = (y_q + 28'sd128) >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == sqs_pkg::StepW'(sqs_pkg::CordicSteps - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= sqs_pkg::CordicK24;
			y_q   <= '0;
			z_q   <= 28'(z_init);
			neg_q <= neg;
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cos_val = neg_q ? -18'(xr) : 18'(xr);
	assign sin_val = neg_q ? -18'(yr) : 18'(yr);

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q)
		else $error("cordic done while running");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("cordic done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> run_q)
		else $error("cordic failed to start");
endmodule
`default_nettype wire

[rtl/core/sqs_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sprite quad setup divider
// restoring divider, one quotient bit per cycle, saturates to q1.16 range
// ----------------------------------------------------------------------------
module sqs_divider (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sqs_pkg::unit_ctl_t ctl,
	input  wire logic [31:0]        numer,
	input  wire logic [15:0]        denom,
	output logic                    done,
	output logic [16:0]             quot
);
	logic [32:0] num_q;
	logic [16:0] rem_q;
	logic [32:0] q_q;
	logic [15:0] den_q;
	logic [sqs_pkg::DivCntW-1:0] cnt_q;
	logic run_q, done_q;
	logic [17:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q, num_q[32]};
	assign diff  = trial - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sqs_pkg::DivCntW'(sqs_pkg::DivBits - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= {1'b0, numer} + {18'd0, denom[15:1]};
			rem_q <= '0;
			q_q   <= '0;
			den_q <= denom;
		end else if (run_q) begin
			num_q <= {num_q[31:0], 1'b0};
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				q_q   <= {q_q[31:0], 1'b1};
			end else begin
				rem_q <= trial[16:0];
				q_q   <= {q_q[31:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = (|q_q[32:17]) ? 17'h1FFFF : q_q[16:0];

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held");
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> run_q)
		else $error("divider failed to start");
	a_done_stop: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q)
		else $error("divider done while running");
endmodule
`default_nettype wire

[rtl/core/sprite_quad_setup.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sprite quad setup
// turns one sprite draw request into four rotated, textured quad vertices
// ----------------------------------------------------------------------------
// req carries one draw request; vtx returns its four vertices, corners 0 to 3,
// last set on corner 3. cfg writes texture_width (index 0) and texture_height
// (index 1); write only while no request is in flight.
// after the request transfer the block reduces the angle, runs a 16-step cordic,
// then four 33-step serial divisions for u0, u1, v0, v1 on one shared divider;
// then one vertex per cycle while vtx.ready is high.
// ready on req is high only while the block is idle. the vertex outputs hold
// while vtx.ready is low and nothing advances until each one is taken.
// reset sets both texture sizes to 1 and the batch slot counter to zero.
// ----------------------------------------------------------------------------
module sprite_quad_setup (
	input  wire logic clk,
	input  wire logic arst_n,
	sqs_req_if.sink   req,
	sqs_vtx_if.source vtx,
	sqs_cfg_if.sink   cfg
);
	sqs_pkg::state_t state_q, state_d;
	logic [15:0] tw_q, th_q;
	logic [12:0] count_q;
	logic [14:0] sx_q, sy_q, dw_q, dh_q;
	logic [15:0] sw_q, sh_q;
	logic signed [15:0] dx_q, dy_q;
	logic signed [16:0] cx2_q, cy2_q;
	logic [1:0]  flags_q;
	logic signed [16:0] ang_q;
	logic signed [26:0] z_d;
	logic neg_d;
	logic [1:0] div_idx_q, k_q;
	logic [16:0] u0_q, u1_q, v0_q, v1_q;
	logic div_busy_q;
	logic signed [17:0] s_q, c_q;
	logic out_valid_q;
	sqs_pkg::unit_ctl_t cor_ctl, div_ctl;
	logic cor_done, div_done;
	logic signed [17:0] sin_w, cos_w;
	logic [16:0] quot;
	logic [31:0] numer;
	logic [15:0] denom;
	logic [15:0] tw_e, th_e;
	logic accept;
	logic [16:0] a_mod;
	logic signed [18:0] a_fold;
	logic signed [17:0] ex, ey;
	logic signed [36:0] rx, ry;
	logic signed [27:0] rxs, rys;

	assign tw_e = (tw_q == 16'd0) ? 16'd1 : tw_q;
	assign th_e = (th_q == 16'd0) ? 16'd1 : th_q;
	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == sqs_pkg::ST_IDLE);
	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= 16'd1;
			th_q <= 16'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				sqs_pkg::RegTexWidth:  tw_q <= cfg.data;
				sqs_pkg::RegTexHeight: th_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// angle mod 360 on a 17-bit q7 value, then folded into +-90 for the cordic
	always_comb begin
		logic signed [18:0] a;
		a = 19'(ang_q);
		if (a < 0) a = a + 19'(sqs_pkg::Deg360);
		if (a < 0) a = a + 19'(sqs_pkg::Deg360);
		if (a >= 19'(sqs_pkg::Deg360)) a = a - 19'(sqs_pkg::Deg360);
		a_mod = a[16:0];
		a_fold = 19'(a_mod);
		if (a_fold > 19'(sqs_pkg::Deg180)) a_fold = a_fold - 19'(sqs_pkg::Deg360);
		if (a_fold > 19'(sqs_pkg::Deg90)) begin
			z_d = 27'(a_fold - 19'(sqs_pkg::Deg180)) <<< 9;
			neg_d = 1'b1;
		end else if (a_fold < -19'(sqs_pkg::Deg90)) begin
			z_d = 27'(a_fold + 19'(sqs_pkg::Deg180)) <<< 9;
			neg_d = 1'b1;
		end else begin
			z_d = 27'(a_fold) <<< 9;
			neg_d = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sqs_pkg::ST_IDLE:   if (accept) state_d = sqs_pkg::ST_ANGLE;
			sqs_pkg::ST_ANGLE:  state_d = sqs_pkg::ST_CORDIC;
			sqs_pkg::ST_CORDIC: if (cor_done) state_d = sqs_pkg::ST_DIVIDE;
			sqs_pkg::ST_DIVIDE: if (div_done && div_idx_q == 2'd3) state_d = sqs_pkg::ST_EMIT;
			sqs_pkg::ST_EMIT:
				if (out_valid_q && vtx.ready && k_q == 2'd3) state_d = sqs_pkg::ST_IDLE;
			default: state_d = sqs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cor_ctl.start = (state_q == sqs_pkg::ST_ANGLE);
		div_ctl.start = (state_q == sqs_pkg::ST_DIVIDE) && !div_busy_q;
	end

	always_comb begin
		case (div_idx_q)
			2'd0:    numer = {1'b0, sx_q, 16'd0};
			2'd1:    numer = {16'(sx_q) + sw_q, 16'd0};
			2'd2:    numer = {1'b0, sy_q, 16'd0};
			default: numer = {16'(sy_q) + sh_q, 16'd0};
		endcase
		denom = div_idx_q[1] ? th_e : tw_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sqs_pkg::ST_IDLE;
			count_q     <= '0;
			div_idx_q   <= '0;
			div_busy_q  <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				div_idx_q <= '0;
				k_q       <= '0;
				if (req.flags[4] || count_q >= sqs_pkg::BatchLimit) count_q <= '0;
			end
			if (div_ctl.start) div_busy_q <= 1'b1;
			if (div_done) begin
				div_busy_q <= 1'b0;
				div_idx_q  <= div_idx_q + 1'b1;
			end
			if (state_q == sqs_pkg::ST_DIVIDE && div_done && div_idx_q == 2'd3)
				out_valid_q <= 1'b1;
			if (out_valid_q && vtx.ready) begin
				k_q <= k_q + 1'b1;
				if (k_q == 2'd3) begin
					out_valid_q <= 1'b0;
					count_q     <= count_q + 13'd4;
				end
			end
		end
	end

	// without a source rectangle the width and height are the full 16-bit texture size
	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.flags[3]) begin
				sx_q <= req.src_x; sy_q <= req.src_y;
				sw_q <= {1'b0, req.src_w}; sh_q <= {1'b0, req.src_h};
			end else begin
				sx_q <= '0; sy_q <= '0;
				sw_q <= tw_e; sh_q <= th_e;
			end
			dx_q <= req.dest_x; dy_q <= req.dest_y;
			dw_q <= req.dest_w; dh_q <= req.dest_h;
			cx2_q <= req.flags[2] ? {req.center_x, 1'b0} : 17'(req.dest_w);
			cy2_q <= req.flags[2] ? {req.center_y, 1'b0} : 17'(req.dest_h);
			flags_q <= req.flags[1:0];
			ang_q <= req.angle;
		end
		if (cor_done) begin
			s_q <= sin_w;
			c_q <= cos_w;
		end
		if (div_done) begin
			case (div_idx_q)
				2'd0:    u0_q <= quot;
				2'd1:    u1_q <= quot;
				2'd2:    v0_q <= quot;
				default: v1_q <= quot;
			endcase
		end
	end

	sqs_cordic u_cordic (
		.clk, .arst_n, .ctl(cor_ctl), .z_init(z_d), .neg(neg_d),
		.done(cor_done), .sin_val(sin_w), .cos_val(cos_w)
	);

	sqs_divider u_divider (
		.clk, .arst_n, .ctl(div_ctl), .numer, .denom, .done(div_done), .quot
	);

	// vertex arithmetic for the corner on show
	always_comb begin
		logic signed [17:0] px2, py2;
		logic signed [36:0] offx, offy;
		px2 = (k_q == 2'd1 || k_q == 2'd2) ? {2'b00, dw_q, 1'b0} : 18'sd0;
		py2 = k_q[1] ? {2'b00, dh_q, 1'b0} : 18'sd0;
		ex = px2 - 18'(cx2_q);
		ey = py2 - 18'(cy2_q);
		offx = (37'(cx2_q) + (37'(dx_q) <<< 1)) <<< 16;
		offy = (37'(cy2_q) + (37'(dy_q) <<< 1)) <<< 16;
		rx = 37'(ex) * 37'(c_q) - 37'(ey) * 37'(s_q) + offx + 37'sd256;
		ry = 37'(ex) * 37'(s_q) + 37'(ey) * 37'(c_q) + offy + 37'sd256;
		rxs = 28'(rx >>> 9);
		rys = 28'(ry >>> 9);
	end

	assign vtx.valid = out_valid_q;
	assign vtx.vertex_x = (rxs > 28'sd8388607) ? 24'sd8388607 :
		(rxs < -28'sd8388608) ? -24'sd8388608 : 24'(rxs);
	assign vtx.vertex_y = (rys > 28'sd8388607) ? 24'sd8388607 :
		(rys < -28'sd8388608) ? -24'sd8388608 : 24'(rys);
	assign vtx.tex_u = (flags_q[0] ^ (k_q == 2'd1 || k_q == 2'd2)) ? u1_q : u0_q;
	assign vtx.tex_v = (flags_q[1] ^ k_q[1]) ? v1_q : v0_q;
	assign vtx.corner = k_q;
	assign vtx.vertex_slot = 12'(count_q + 13'(k_q));
	assign vtx.last = (k_q == 2'd3);

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !req.ready)
		else $error("request taken while vertices pending");
	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && vtx.ready && k_q == 2'd3) |=> !out_valid_q)
		else $error("vertex valid after last transfer");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && vtx.ready && k_q == 2'd3) |=> count_q == $past(count_q) + 13'd4)
		else $error("batch count not advanced");
endmodule
`default_nettype wire
